@@ hdl/smpq_pkg.sv @@
// Shared sizes, status codes and command/status bundles for the sorted
// min-priority queue. No dependencies.
package smpq_pkg;

   localparam int CAPACITY = 16;
   localparam int KEY_W    = 31;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OCC_W    = 5;
   localparam int STAT_W   = 2;

   localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] STAT_POPPED   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic ins_en;
      logic pop_en;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
   } dp_stat_type;

endpackage

@@ hdl/smpq_datapath.sv @@
// Key storage as a row of compare-and-shift cells plus the key count.
// Depends on smpq_pkg.
module smpq_datapath import smpq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   input  logic [KEY_W-1:0]        req_key,
   output dp_stat_type             stat,
   output logic [KEY_W-1:0]        popped_key,
   output logic [OCC_W-1:0]        occupancy
);

   logic [KEY_W-1:0] keys_ff [CAPACITY];
   logic [KEY_W-1:0] keys_in [CAPACITY];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0] popped_ff, popped_in;
   logic [CAPACITY-1:0] take;

   // Each cell decides on its own whether it is at or past the insert point.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         take[i] = ((CNT_W'(i) < count_ff) && (keys_ff[i] > req_key)) ||
                   (CNT_W'(i) == count_ff);
      end
   end

   always_comb begin
      count_in  = count_ff;
      popped_in = popped_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         keys_in[i] = keys_ff[i];
      end
      if (cmd.ins_en) begin
         // shift the tail up by one, drop the new key into the gap
         for (int i = 0; i < CAPACITY; i++) begin
            if (take[i]) begin
               if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
                  keys_in[i] = keys_ff[(i > 0) ? i - 1 : 0];
               end else begin
                  keys_in[i] = req_key;
               end
            end
         end
         count_in  = count_ff + CNT_W'(1);
         popped_in = '0;
      end else if (cmd.pop_en) begin
         // advance every cell but the last toward the head
         for (int i = 0; i < CAPACITY - 1; i++) begin
            keys_in[i] = keys_ff[i + 1];
         end
         count_in  = count_ff - CNT_W'(1);
         popped_in = keys_ff[0];
      end else begin
         popped_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         keys_ff[i] <= keys_in[i];
      end
      popped_ff <= popped_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.full  = (count_ff == CNT_W'(CAPACITY));
   assign stat.empty = (count_ff == '0);
   assign popped_key = popped_ff;
   assign occupancy  = OCC_W'(count_ff);

endmodule

@@ hdl/smpq_ctrl.sv @@
// Command decode and response sequencing for the sorted min-priority queue.
// Depends on smpq_pkg.
module smpq_ctrl import smpq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   input  logic               req_mode,
   input  dp_stat_type        stat,
   output logic               busy,
   output dp_cmd_type         cmd,
   output logic               rsp_strobe,
   output logic [STAT_W-1:0]  rsp_status
);

   typedef enum logic {
      S_IDLE,
      S_REPLY
   } state_type;

   state_type         state_ff, state_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              accept;

   assign busy   = 1'b0;
   assign accept = req_start && !busy;

   always_comb begin
      cmd.ins_en = accept && (req_mode == MODE_INSERT) && !stat.full;
      cmd.pop_en = accept && (req_mode == MODE_POP) && !stat.empty;
      state_in   = accept ? S_REPLY : S_IDLE;
      status_in  = status_ff;
      if (accept) begin
         unique case ({req_mode, (req_mode == MODE_POP) ? stat.empty : stat.full})
            2'b00:   status_in = STAT_INSERTED;
            2'b01:   status_in = STAT_FULL;
            2'b10:   status_in = STAT_POPPED;
            default: status_in = STAT_EMPTY;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= STAT_INSERTED;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign rsp_strobe = (state_ff == S_REPLY);
   assign rsp_status = status_ff;

endmodule

@@ hdl/sorted_min_priority_queue_core.sv @@
// Sorted min-priority queue, 16 keys of 31 bits, ascending, stable on ties.
// A word accepted at an edge shows its result (strobe) in the next cycle.
// Throughput: one word per cycle; busy stays low, and the cell row applies an
// insert or pop as the word is accepted. Synchronous active-high reset empties
// the queue; key storage holds no reset value and is read only once written.
module sorted_min_priority_queue_core import smpq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [KEY_W-1:0]   req_key,
   output logic               rsp_strobe,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [KEY_W-1:0]   rsp_popped_key,
   output logic [OCC_W-1:0]   rsp_occupancy
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Controller: decode the word against full/empty, sequence the result.
   smpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_mode   (req_mode),
      .stat       (stat),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status)
   );

   // Datapath: shift row of key cells; popped key and count are registered
   // so they line up with the strobe cycle.
   smpq_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_key    (req_key),
      .stat       (stat),
      .popped_key (rsp_popped_key),
      .occupancy  (rsp_occupancy)
   );

endmodule

@@ hdl/smpq_checker.sv @@
// Port-level checks for the sorted min-priority queue, bound to the top.
// Depends on smpq_pkg and sorted_min_priority_queue_core.
module smpq_checker import smpq_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [STAT_W-1:0]  rsp_status,
   input logic [KEY_W-1:0]   rsp_popped_key,
   input logic [OCC_W-1:0]   rsp_occupancy
);

   a_reply_follows: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy) |=> rsp_strobe)
      else $error("accepted word got no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(req_start && !busy) |=> !rsp_strobe)
      else $error("result without a word");

   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STAT_POPPED) |-> (rsp_popped_key == '0))
      else $error("nonzero key on non-pop result");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STAT_FULL) |-> (rsp_occupancy == OCC_W'(CAPACITY)))
      else $error("full reported below capacity");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STAT_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty reported with keys held");

endmodule

bind sorted_min_priority_queue_core smpq_checker u_smpq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_start      (req_start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_popped_key (rsp_popped_key),
   .rsp_occupancy  (rsp_occupancy)
);

@@ dv/sorted_min_priority_queue_core_tb.sv @@
// Self-checking bench for sorted_min_priority_queue_core: random insert/pop words
// against an in-bench mirror of the sorted key store and its reply scoreboard.
// Depends on smpq_pkg and the core RTL only.
`timescale 1ns / 100ps

module sorted_min_priority_queue_core_tb;
   import smpq_pkg::*;

   localparam int               CYCLE_LIMIT  = 200_000;
   localparam int               RANDOM_WORDS = 1230;
   localparam int               TAIL_CYCLES  = 4;
   localparam logic [KEY_W-1:0] KEY_TOP      = '1;

   // One expected reply, field for field as the rsp_ ports carry it.
   typedef struct {
      logic [STAT_W-1:0] status;
      logic [KEY_W-1:0]  popped_key;
      logic [OCC_W-1:0]  occupancy;
   } queue_reply_type;

   // Mirror of the key store plus the replies still owed by the block.
   class pq_scoreboard_type;
      logic [KEY_W-1:0] mirror_keys[$];
      queue_reply_type  pending_replies[$];
      int               error_count = 0;

      task report(string what);
         error_count++;
         $display("MISMATCH @%0t: %s", $time, what);
      endtask

      // Apply an accepted word to the mirror and queue the reply it owes.
      function void note_word(logic mode, logic [KEY_W-1:0] key);
         queue_reply_type r;
         int              slot;
         r.popped_key = '0;
         if (mode == MODE_INSERT) begin
            if (mirror_keys.size() >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               // Land just ahead of the first strictly greater key: ties stay FIFO.
               slot = mirror_keys.size();
               for (int j = 0; j < mirror_keys.size(); j++) begin
                  if (mirror_keys[j] > key) begin
                     slot = j;
                     break;
                  end
               end
               mirror_keys.insert(slot, key);
               r.status = STAT_INSERTED;
            end
         end else if (mirror_keys.size() == 0) begin
            r.status = STAT_EMPTY;
         end else begin
            r.popped_key = mirror_keys.pop_front();
            r.status     = STAT_POPPED;
         end
         r.occupancy = OCC_W'(mirror_keys.size());
         pending_replies.push_back(r);
      endfunction

      task check_reply(logic [STAT_W-1:0] status, logic [KEY_W-1:0] popped_key,
                       logic [OCC_W-1:0] occupancy);
         queue_reply_type want;
         if (pending_replies.size() == 0) begin
            report("reply strobe with no word outstanding");
            return;
         end
         want = pending_replies.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, want %0d", status, want.status));
         if (popped_key !== want.popped_key)
            report($sformatf("popped_key 0x%08h, want 0x%08h", popped_key,
                             want.popped_key));
         if (occupancy !== want.occupancy)
            report($sformatf("occupancy %0d, want %0d", occupancy, want.occupancy));
      endtask
   endclass

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_start = 1'b0;
   logic               req_mode  = MODE_INSERT;
   logic [KEY_W-1:0]   req_key   = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [STAT_W-1:0]  rsp_status;
   logic [KEY_W-1:0]   rsp_popped_key;
   logic [OCC_W-1:0]   rsp_occupancy;

   pq_scoreboard_type board = new();
   int                words_accepted = 0;
   int                cycle_count    = 0;

   sorted_min_priority_queue_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_start      (req_start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_popped_key (rsp_popped_key),
      .rsp_occupancy  (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sample both channels at the rising edge. Check the reply first: it
   // belongs to a word taken at an earlier edge, so its expectation is queued.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_strobe === 1'b1)
            board.check_reply(rsp_status, rsp_popped_key, rsp_occupancy);
         else if (rsp_strobe !== 1'b0)
            board.report("rsp_strobe unknown");
         if (req_start && busy === 1'b0) begin
            board.note_word(req_mode, req_key);
            words_accepted++;
         end
      end
   end

   // Hard stop in case a reply never shows or the handshake locks up.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // Keys lean on the edges: zero, all ones or just below, a small range for ties, else anything.
   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return KEY_TOP;
         2, 3, 4: return KEY_W'($urandom_range(0, 15));
         5:       return KEY_TOP - KEY_W'($urandom_range(0, 3));
         default: return KEY_W'($urandom);
      endcase
   endfunction

   // Enter and leave at a falling edge. Idle for the gap with noise on
   // the data lines, then hold the word until the monitor sees it taken.
   task send_word(logic mode, logic [KEY_W-1:0] key, int gap);
      int target;
      if (gap > 0) begin
         req_start <= 1'b0;
         req_mode  <= 1'($urandom);
         req_key   <= KEY_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_start <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      target = words_accepted + 1;
      do @(negedge clock); while (words_accepted < target);
   endtask

   // Drop start and hold off until every owed reply has come back.
   task hold_until_drained();
      req_start <= 1'b0;
      while (board.pending_replies.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   initial begin
      int  sent;
      int  chunk_len;
      int  insert_pct;
      bit  steady;
      logic mode;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: pop on empty, both key extremes, a tie run, fill to
      // capacity, two inserts into a full queue, then a few pops.
      send_word(MODE_POP, KEY_TOP, 0);
      send_word(MODE_INSERT, '0, $urandom_range(0, 5));
      send_word(MODE_INSERT, KEY_TOP, $urandom_range(0, 5));
      repeat (3) send_word(MODE_INSERT, KEY_W'(5), 0);
      repeat (CAPACITY - 5) send_word(MODE_INSERT, pick_key(), $urandom_range(0, 5));
      send_word(MODE_INSERT, '0, 0);
      send_word(MODE_INSERT, KEY_TOP, 1);
      repeat (4) send_word(MODE_POP, KEY_W'($urandom), $urandom_range(0, 2));
      hold_until_drained();

      // Random: chunks with a drifting insert bias so the queue swings
      // between empty and full; some chunks run back to back.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         chunk_len = $urandom_range(20, 60);
         case ($urandom_range(0, 3))
            0:       insert_pct = 20;
            1:       insert_pct = 50;
            2:       insert_pct = 80;
            default: insert_pct = 95;
         endcase
         steady = ($urandom_range(0, 3) == 0);
         repeat (chunk_len) begin
            mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_POP;
            send_word(mode, pick_key(), steady ? 0 : $urandom_range(0, 5));
            sent++;
         end
         if ($urandom_range(0, 4) == 0)
            hold_until_drained();
      end

      // Drain, then idle through the tail so a stray reply can show up.
      hold_until_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (board.pending_replies.size() != 0)
         board.report("replies still owed at end of run");
      if (board.error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/smpq_pkg.sv
hdl/smpq_datapath.sv
hdl/smpq_ctrl.sv
hdl/sorted_min_priority_queue_core.sv
hdl/smpq_checker.sv
dv/sorted_min_priority_queue_core_tb.sv
